FILE: rtl/itmh_pkg.sv
// shared types, constants and helpers of the indexed timer min-heap
`default_nettype none

package itmh_pkg;

    // heap and id space sizes
    localparam int HEAP_CAPACITY = 32;
    localparam int HA_W          = $clog2(HEAP_CAPACITY);
    localparam int CNT_W         = $clog2(HEAP_CAPACITY + 1);
    localparam int IW            = HA_W + 2;
    localparam int ID_W          = 10;
    localparam int ID_SPACE      = 1 << ID_W;
    localparam int TIME_BITS     = 32;
    localparam int TMO_W         = 20;
    localparam int DELAY_W       = 20;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 3;

    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADJUST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELAY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] exp;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOK_HEAP,
        S_LOOK_CHK,
        S_EMIT_FIRE,
        S_REM_START,
        S_REM_LOAD,
        S_SD_L,
        S_SD_R,
        S_SD_CMP,
        S_SU_RD,
        S_SU_CMP,
        S_FIN,
        S_EXP_RD,
        S_EXP_CHK,
        S_EMIT_EXP,
        S_EMIT_DONE,
        S_EMIT_FULL,
        S_EMIT_UNK,
        S_EMIT_DELAY,
        S_EMIT_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        ADR_SLOT,
        ADR_LAST,
        ADR_LEFT,
        ADR_RIGHT,
        ADR_PARENT,
        ADR_ROOT
    } addr_sel_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_SLOT,
        POS_COUNT,
        POS_ZERO,
        POS_PICK,
        POS_PARENT
    } pos_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PICK,
        WR_PARENT,
        WR_E
    } wr_sel_t;

    typedef enum logic [2:0] {
        EM_DONE,
        EM_FIRE,
        EM_EXP,
        EM_DELAY,
        EM_EMPTY,
        EM_FULL,
        EM_UNK
    } emit_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      latch_in;
        logic      slot_rd;
        logic      heap_rd;
        addr_sel_t addr_sel;
        logic      now_inc;
        logic      count_clr;
        logic      count_inc;
        logic      count_dec;
        logic      load_e_new;
        logic      load_e_rd;
        pos_sel_t  pos_sel;
        logic      save_left;
        wr_sel_t   wr_sel;
        logic      moved_set;
        logic      emit;
        emit_t     emit_kind;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic known;
        logic full;
        logic empty;
        logic pos_lt_last;
        logic left_in;
        logic right_in;
        logic pos_zero;
        logic moved;
        logic e_before_pick;
        logic parent_before_e;
        logic root_due;
        logic out_free;
    } stat_t;

    // a is strictly earlier than b in wrapping time
    function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return d[TIME_BITS-1];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/itmh_if.sv
// handshake channels for timer operations and their results
`default_nettype none

interface itmh_in_if import itmh_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [ID_W-1:0]      timer_id;
    logic [TMO_W-1:0]     timeout_ms;

    modport source (output valid, mode, timer_id, timeout_ms, input ready);
    modport sink   (input valid, mode, timer_id, timeout_ms, output ready);
endinterface

interface itmh_out_if import itmh_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      out_id;
    logic [DELAY_W-1:0]   delay_ms;
    logic                 last;

    modport source (output valid, status, out_id, delay_ms, last, input ready);
    modport sink   (input valid, status, out_id, delay_ms, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/itmh_ctrl.sv
// sequencer for heap operations, sifting and expiry
`default_nettype none

module itmh_ctrl import itmh_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    state_t post_fin;
    state_t post_rem;
    logic   is_tick;

    assign is_tick = (stat.mode == MODE_TICK);

    // where to go once a sift or a removal finishes
    always_comb
    begin
        if (stat.mode == MODE_FIRE)
            post_rem = S_IDLE;
        else
            post_rem = S_EXP_RD;
        if (stat.mode == MODE_ADD || stat.mode == MODE_ADJUST)
            post_fin = S_EMIT_DONE;
        else
            post_fin = post_rem;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                if (stat.mode == MODE_ADD || stat.mode == MODE_FIRE
                    || stat.mode == MODE_ADJUST)
                    state_next = S_LOOK_HEAP;
                else if (stat.mode == MODE_TICK || stat.mode == MODE_NEXT)
                    state_next = S_EXP_RD;
                else
                    state_next = S_EMIT_DONE;
            S_LOOK_HEAP:
                state_next = S_LOOK_CHK;
            S_LOOK_CHK:
                priority if (stat.known && stat.mode == MODE_FIRE)
                    state_next = S_EMIT_FIRE;
                else if (stat.known)
                    state_next = S_SD_L;
                else if (stat.mode != MODE_ADD)
                    state_next = S_EMIT_UNK;
                else if (stat.full)
                    state_next = S_EMIT_FULL;
                else
                    state_next = S_SU_RD;
            S_EMIT_FIRE:
                if (stat.out_free)
                    state_next = S_REM_START;
            S_REM_START:
                if (stat.pos_lt_last)
                    state_next = S_REM_LOAD;
                else
                    state_next = post_rem;
            S_REM_LOAD:
                state_next = S_SD_L;
            S_SD_L:
                priority if (stat.left_in)
                    state_next = S_SD_R;
                else if (stat.moved)
                    state_next = S_FIN;
                else
                    state_next = S_SU_RD;
            S_SD_R:
                state_next = S_SD_CMP;
            S_SD_CMP:
                priority if (!stat.e_before_pick)
                    state_next = S_SD_L;
                else if (stat.moved)
                    state_next = S_FIN;
                else
                    state_next = S_SU_RD;
            S_SU_RD:
                if (stat.pos_zero)
                    state_next = S_FIN;
                else
                    state_next = S_SU_CMP;
            S_SU_CMP:
                if (stat.parent_before_e)
                    state_next = S_FIN;
                else
                    state_next = S_SU_RD;
            S_FIN:
                state_next = post_fin;
            S_EXP_RD:
                priority if (!stat.empty)
                    state_next = S_EXP_CHK;
                else if (is_tick)
                    state_next = S_EMIT_DONE;
                else
                    state_next = S_EMIT_EMPTY;
            S_EXP_CHK:
                priority if (stat.root_due)
                    state_next = S_EMIT_EXP;
                else if (is_tick)
                    state_next = S_EMIT_DONE;
                else
                    state_next = S_EMIT_DELAY;
            S_EMIT_EXP:
                if (stat.out_free)
                    state_next = S_REM_START;
            S_EMIT_DONE, S_EMIT_FULL, S_EMIT_UNK, S_EMIT_DELAY, S_EMIT_EMPTY:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ADR_ROOT;
        cmd.pos_sel  = POS_HOLD;
        cmd.wr_sel   = WR_NONE;
        cmd.emit_kind = EM_DONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            S_DISPATCH:
            begin
                cmd.slot_rd   = (stat.mode == MODE_ADD || stat.mode == MODE_FIRE
                                 || stat.mode == MODE_ADJUST);
                cmd.now_inc   = (stat.mode == MODE_TICK);
                cmd.count_clr = (stat.mode == MODE_CLEAR);
            end
            S_LOOK_HEAP:
            begin
                cmd.heap_rd  = 1'b1;
                cmd.addr_sel = ADR_SLOT;
            end
            S_LOOK_CHK:
                priority if (stat.known && stat.mode == MODE_FIRE)
                    cmd.pos_sel = POS_SLOT;
                else if (stat.known)
                begin
                    cmd.pos_sel    = POS_SLOT;
                    cmd.load_e_new = 1'b1;
                end
                else if (stat.mode == MODE_ADD && !stat.full)
                begin
                    cmd.pos_sel    = POS_COUNT;
                    cmd.load_e_new = 1'b1;
                    cmd.count_inc  = 1'b1;
                end
                else
                    cmd.pos_sel = POS_HOLD;
            S_EMIT_FIRE:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_FIRE;
            end
            S_REM_START:
            begin
                cmd.count_dec = 1'b1;
                cmd.heap_rd   = stat.pos_lt_last;
                cmd.addr_sel  = ADR_LAST;
            end
            S_REM_LOAD:
                cmd.load_e_rd = 1'b1;
            S_SD_L:
            begin
                cmd.heap_rd  = stat.left_in;
                cmd.addr_sel = ADR_LEFT;
            end
            S_SD_R:
            begin
                cmd.save_left = 1'b1;
                cmd.heap_rd   = stat.right_in;
                cmd.addr_sel  = ADR_RIGHT;
            end
            S_SD_CMP:
                if (!stat.e_before_pick)
                begin
                    cmd.wr_sel    = WR_PICK;
                    cmd.pos_sel   = POS_PICK;
                    cmd.moved_set = 1'b1;
                end
            S_SU_RD:
            begin
                cmd.heap_rd  = !stat.pos_zero;
                cmd.addr_sel = ADR_PARENT;
            end
            S_SU_CMP:
                if (!stat.parent_before_e)
                begin
                    cmd.wr_sel  = WR_PARENT;
                    cmd.pos_sel = POS_PARENT;
                end
            S_FIN:
                cmd.wr_sel = WR_E;
            S_EXP_RD:
            begin
                cmd.heap_rd  = !stat.empty;
                cmd.addr_sel = ADR_ROOT;
            end
            S_EXP_CHK:
                cmd.pos_sel = POS_ZERO;
            S_EMIT_EXP:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_EXP;
            end
            S_EMIT_DONE:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_DONE;
            end
            S_EMIT_FULL:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_FULL;
            end
            S_EMIT_UNK:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_UNK;
            end
            S_EMIT_DELAY:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_DELAY;
            end
            S_EMIT_EMPTY:
            begin
                cmd.emit      = stat.out_free;
                cmd.emit_kind = EM_EMPTY;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/itmh_dp.sv
// heap and slot memories, clock, counters and the result register
`default_nettype none

module itmh_dp import itmh_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [MODE_W-1:0]     in_mode,
    input  wire logic [ID_W-1:0]       in_timer_id,
    input  wire logic [TMO_W-1:0]      in_timeout_ms,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STATUS_W-1:0]        out_status,
    output logic [ID_W-1:0]            out_id,
    output logic [DELAY_W-1:0]         out_delay_ms,
    output logic                       out_last
);

    entry_t              heap_mem [HEAP_CAPACITY];
    logic [HA_W-1:0]     slot_mem [ID_SPACE];

    // control state
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 out_valid_reg;

    // payload registers
    logic [MODE_W-1:0]    mode_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TMO_W-1:0]     tmo_reg;
    logic [HA_W-1:0]      slot_rd_reg;
    entry_t               heap_rd_reg;
    entry_t               e_reg;
    entry_t               left_reg;
    logic                 rvalid_reg;
    logic                 moved_reg;
    logic [HA_W-1:0]      pos_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [ID_W-1:0]      oid_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic                 last_reg;

    logic [IW-1:0]        pos_w;
    logic [IW-1:0]        cnt_w;
    logic [IW-1:0]        left_w;
    logic [IW-1:0]        right_w;
    logic [HA_W-1:0]      parent;
    logic                 pick_r;
    entry_t               pick_e;
    logic [HA_W-1:0]      pick_idx;
    logic [HA_W-1:0]      rd_addr;
    entry_t               wd;
    logic [TIME_BITS-1:0] root_d;
    logic [DELAY_W-1:0]   delay_val;
    logic                 out_free;

    // index arithmetic
    always_comb
    begin
        pos_w    = IW'(pos_reg);
        cnt_w    = IW'(count_reg);
        left_w   = (pos_w << 1) + IW'(1);
        right_w  = (pos_w << 1) + IW'(2);
        parent   = HA_W'((pos_w - IW'(1)) >> 1);
        pick_r   = rvalid_reg && earlier(heap_rd_reg.exp, left_reg.exp);
        pick_e   = pick_r ? heap_rd_reg : left_reg;
        pick_idx = pick_r ? right_w[HA_W-1:0] : left_w[HA_W-1:0];
    end

    // root delay, floored and saturated
    always_comb
    begin
        root_d = heap_rd_reg.exp - now_reg;
        if (root_d[TIME_BITS-1])
            delay_val = '0;
        else if (root_d > TIME_BITS'(DELAY_MAX))
            delay_val = DELAY_MAX;
        else
            delay_val = root_d[DELAY_W-1:0];
    end

    // status to the controller
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.mode            = mode_reg;
        stat.known           = (IW'(slot_rd_reg) < cnt_w) && (heap_rd_reg.id == id_reg);
        stat.full            = (cnt_w >= IW'(HEAP_CAPACITY));
        stat.empty           = (count_reg == '0);
        stat.pos_lt_last     = (pos_w + IW'(1) < cnt_w);
        stat.left_in         = (left_w < cnt_w);
        stat.right_in        = (right_w < cnt_w);
        stat.pos_zero        = (pos_reg == '0);
        stat.moved           = moved_reg;
        stat.e_before_pick   = earlier(e_reg.exp, pick_e.exp);
        stat.parent_before_e = earlier(heap_rd_reg.exp, e_reg.exp);
        stat.root_due        = (root_d == '0) || root_d[TIME_BITS-1];
        stat.out_free        = out_free;
    end

    // heap read address and write data
    always_comb
    begin
        unique case (cmd.addr_sel)
            ADR_SLOT:   rd_addr = slot_rd_reg;
            ADR_LAST:   rd_addr = HA_W'(cnt_w - IW'(1));
            ADR_LEFT:   rd_addr = left_w[HA_W-1:0];
            ADR_RIGHT:  rd_addr = right_w[HA_W-1:0];
            ADR_PARENT: rd_addr = parent;
            default:    rd_addr = '0;
        endcase
        unique case (cmd.wr_sel)
            WR_PICK:   wd = pick_e;
            WR_PARENT: wd = heap_rd_reg;
            default:   wd = e_reg;
        endcase
    end

    // heap memory
    always_ff @(posedge clk)
    begin
        if (cmd.heap_rd)
            heap_rd_reg <= heap_mem[rd_addr];
        if (cmd.wr_sel != WR_NONE)
            heap_mem[pos_reg] <= wd;
    end

    // id to slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.slot_rd)
            slot_rd_reg <= slot_mem[id_reg];
        if (cmd.wr_sel != WR_NONE)
            slot_mem[wd.id] <= pos_reg;
    end

    // count, clock and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_clr)
                count_reg <= '0;
            else if (cmd.count_inc)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.count_dec)
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.now_inc)
                now_reg <= now_reg + TIME_BITS'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // operation, sift and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg <= in_mode;
            id_reg   <= in_timer_id;
            tmo_reg  <= in_timeout_ms;
        end
        if (cmd.load_e_new)
        begin
            e_reg.id  <= id_reg;
            e_reg.exp <= now_reg + TIME_BITS'(tmo_reg);
        end
        else if (cmd.load_e_rd)
            e_reg <= heap_rd_reg;
        if (cmd.load_e_new || cmd.load_e_rd)
            moved_reg <= 1'b0;
        else if (cmd.moved_set)
            moved_reg <= 1'b1;
        if (cmd.save_left)
        begin
            left_reg   <= heap_rd_reg;
            rvalid_reg <= stat.right_in;
        end
        unique case (cmd.pos_sel)
            POS_SLOT:   pos_reg <= slot_rd_reg;
            POS_COUNT:  pos_reg <= HA_W'(count_reg);
            POS_ZERO:   pos_reg <= '0;
            POS_PICK:   pos_reg <= pick_idx;
            POS_PARENT: pos_reg <= parent;
            default:    pos_reg <= pos_reg;
        endcase
        if (cmd.emit)
        begin
            oid_reg   <= '0;
            delay_reg <= '0;
            last_reg  <= 1'b1;
            unique case (cmd.emit_kind)
                EM_FIRE:
                begin
                    status_reg <= ST_EXPIRED;
                    oid_reg    <= id_reg;
                end
                EM_EXP:
                begin
                    status_reg <= ST_EXPIRED;
                    oid_reg    <= heap_rd_reg.id;
                    last_reg   <= 1'b0;
                end
                EM_DELAY:
                begin
                    status_reg <= ST_DELAY;
                    delay_reg  <= delay_val;
                end
                EM_EMPTY: status_reg <= ST_EMPTY;
                EM_FULL:  status_reg <= ST_FULL;
                EM_UNK:   status_reg <= ST_UNKNOWN;
                default:  status_reg <= ST_DONE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = status_reg;
    assign out_id       = oid_reg;
    assign out_delay_ms = delay_reg;
    assign out_last     = last_reg;

endmodule

`default_nettype wire

FILE: rtl/indexed_timer_min_heap.sv
// indexed timer min-heap: top level joining controller and datapath
// one operation at a time; add and adjust look up the id's slot and heap entry;
// add then sifts up from the end, adjust sifts down (left read, right read, compare
// per level) or up (parent read, compare per level), and the entry is written back;
// fire emits after the lookup, then moves the last entry into its slot and sifts it
// tick and next delay check the root, emitting and removing each expired timer
// reset clears time, entry count and result valid; the memories are not swept,
// an id counts as present only when its slot is live and holds that same id
`default_nettype none

module indexed_timer_min_heap import itmh_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    itmh_in_if.sink   req,
    itmh_out_if.source res
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    itmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and arithmetic
    itmh_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mode       (req.mode),
        .in_timer_id   (req.timer_id),
        .in_timeout_ms (req.timeout_ms),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .out_status    (res.status),
        .out_id        (res.out_id),
        .out_delay_ms  (res.delay_ms),
        .out_last      (res.last)
    );

endmodule

`default_nettype wire
